[rtl/epcal_pkg.sv]
`default_nettype none
package epcal_pkg;

    // bias that makes every input non-negative, a whole number of days
    localparam logic [32:0] DAY_BIAS  = 33'd2147558400;
    localparam logic [26:0] DAY_RECIP = 27'd101806633;
    localparam logic [25:0] DAY_DIV   = 26'd675;
    localparam logic [17:0] SEC_RECIP = 18'd139811;
    localparam logic [16:0] CYC_RECIP = 17'd91868;
    localparam logic [16:0] WD_RECIP  = 17'd74899;
    localparam logic [16:0] HR_RECIP  = 17'd69906;
    // day count from 1901-01-01 and weekday phase
    localparam logic [15:0] CYC_OFFS  = 16'd346;
    localparam logic [15:0] WD_OFFS   = 16'd5;
    localparam logic [15:0] CYC_DAYS  = 16'd1461;
    localparam logic [10:0] YEAR_DAYS = 11'd365;

    typedef struct packed {
        logic [15:0] day;
        logic [16:0] sod;
    } split_t;

    typedef struct packed {
        logic [5:0] second;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [4:0] month_day;
        logic [3:0] month;
        logic [7:0] years_since_1900;
        logic [2:0] weekday;
        logic [8:0] year_day;
    } cal_t;

    function automatic logic [8:0] month_start(input logic [3:0] mon, input logic leap);
        logic [8:0] base;
        begin
            case (mon)
                4'd0:    base = 9'd0;
                4'd1:    base = 9'd31;
                4'd2:    base = 9'd59;
                4'd3:    base = 9'd90;
                4'd4:    base = 9'd120;
                4'd5:    base = 9'd151;
                4'd6:    base = 9'd181;
                4'd7:    base = 9'd212;
                4'd8:    base = 9'd243;
                4'd9:    base = 9'd273;
                4'd10:   base = 9'd304;
                4'd11:   base = 9'd334;
                default: base = 9'd0;
            endcase
            if (leap && mon >= 4'd2) begin
                base = base + 9'd1;
            end
            return base;
        end
    endfunction

endpackage
`default_nettype wire

[rtl/epcal_daysplit.sv]
`default_nettype none
module epcal_daysplit
    import epcal_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        en,
    input  wire logic        in_valid,
    input  wire logic [31:0] in_seconds,
    output logic             out_valid,
    output split_t           out_split
);
    logic [2:0]  vld_reg;
    logic [32:0] biased;
    logic [25:0] q1_reg, q2_reg;
    logic [6:0]  lo1_reg, lo2_reg;
    logic [52:0] prod_reg;
    logic [52:0] prod_next;
    logic [15:0] day_est;
    logic [25:0] rem_full;
    split_t      split_reg, split_next;

    assign biased    = {in_seconds[31], in_seconds} + DAY_BIAS;
    assign prod_next = {27'd0, q1_reg} * {26'd0, DAY_RECIP};
    assign day_est   = prod_reg[51:36];
    assign rem_full  = q2_reg - ({10'd0, day_est} * DAY_DIV);

    always_comb begin
        split_next.day = day_est;
        split_next.sod = {rem_full[9:0], lo2_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q1_reg    <= biased[32:7];
            lo1_reg   <= biased[6:0];
            prod_reg  <= prod_next;
            q2_reg    <= q1_reg;
            lo2_reg   <= lo1_reg;
            split_reg <= split_next;
        end
    end

    assign out_valid = vld_reg[2];
    assign out_split = split_reg;

endmodule
`default_nettype wire

[rtl/epcal_fields.sv]
`default_nettype none
module epcal_fields
    import epcal_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   en,
    input  wire logic   in_valid,
    input  wire split_t in_split,
    output logic        out_valid,
    output cal_t        out_cal
);
    logic [3:0]  vld_reg;

    // products
    logic [15:0] dp_reg, dw_reg;
    logic [16:0] sod4_reg;
    logic [34:0] psec_reg;
    logic [32:0] pyr_reg, pwd_reg;

    // quotients and remainders
    logic [10:0] mt_next, mt5_reg, mt6_reg;
    logic [16:0] sec_full;
    logic [5:0]  sec5_reg, sec6_reg;
    logic [5:0]  cyc_next, cyc_reg;
    logic [15:0] rem_full;
    logic [10:0] rem_reg;
    logic [15:0] wd_full;
    logic [2:0]  wd5_reg, wd6_reg;

    // year
    logic [1:0]  yic;
    logic [10:0] yday_full;
    logic [27:0] phr_reg;
    logic [7:0]  ys_reg;
    logic [8:0]  yday_reg;
    logic        leap_reg;

    // month and time of day
    logic [4:0]  hour_est;
    logic [10:0] min_full;
    logic [3:0]  mon;
    logic [8:0]  mday_full;
    cal_t        cal_reg, cal_next;

    assign mt_next  = psec_reg[33:23];
    assign sec_full = sod4_reg - ({6'd0, mt_next} * 17'd60);
    assign cyc_next = pyr_reg[32:27];
    assign rem_full = dp_reg - ({10'd0, cyc_next} * CYC_DAYS);
    assign wd_full  = dw_reg - ({2'd0, pwd_reg[32:19]} * 16'd7);

    always_comb begin
        if (rem_reg < YEAR_DAYS) begin
            yic = 2'd0;
        end else if (rem_reg < 11'd730) begin
            yic = 2'd1;
        end else if (rem_reg < 11'd1095) begin
            yic = 2'd2;
        end else begin
            yic = 2'd3;
        end
    end
    assign yday_full = rem_reg - ({9'd0, yic} * YEAR_DAYS);

    assign hour_est = phr_reg[26:22];
    assign min_full = mt6_reg - ({6'd0, hour_est} * 11'd60);

    always_comb begin
        mon = 4'd0;
        for (int m = 1; m < 12; m++) begin
            if (yday_reg >= month_start(4'(m), leap_reg)) begin
                mon = 4'(m);
            end
        end
    end
    assign mday_full = yday_reg - month_start(mon, leap_reg) + 9'd1;

    always_comb begin
        cal_next.second           = sec6_reg;
        cal_next.minute           = min_full[5:0];
        cal_next.hour             = hour_est;
        cal_next.month_day        = mday_full[4:0];
        cal_next.month            = mon;
        cal_next.years_since_1900 = ys_reg;
        cal_next.weekday          = wd6_reg;
        cal_next.year_day         = yday_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dp_reg   <= in_split.day + CYC_OFFS;
            dw_reg   <= in_split.day + WD_OFFS;
            sod4_reg <= in_split.sod;
            psec_reg <= {18'd0, in_split.sod} * {17'd0, SEC_RECIP};
            pyr_reg  <= {17'd0, (in_split.day + CYC_OFFS)} * {16'd0, CYC_RECIP};
            pwd_reg  <= {17'd0, (in_split.day + WD_OFFS)} * {16'd0, WD_RECIP};

            mt5_reg  <= mt_next;
            sec5_reg <= sec_full[5:0];
            cyc_reg  <= cyc_next;
            rem_reg  <= rem_full[10:0];
            wd5_reg  <= wd_full[2:0];

            phr_reg  <= {17'd0, mt5_reg} * {11'd0, HR_RECIP};
            mt6_reg  <= mt5_reg;
            sec6_reg <= sec5_reg;
            wd6_reg  <= wd5_reg;
            ys_reg   <= 8'd1 + {cyc_reg, 2'd0} + {6'd0, yic};
            yday_reg <= yday_full[8:0];
            leap_reg <= (yic == 2'd3);

            cal_reg  <= cal_next;
        end
    end

    assign out_valid = vld_reg[3];
    assign out_cal   = cal_reg;

endmodule
`default_nettype wire

[rtl/epoch_seconds_to_utc_calendar.sv]
// each input word passes through the day split registers, then the calendar field registers, to the result word
// throughput: one word per cycle; a stalled output holds the whole pipeline
// the day split, calendar fields and output word are separate register stages
// reset (aresetn low, synchronous) clears all valid bits; data registers keep their value
`default_nettype none
module epoch_seconds_to_utc_calendar
    import epcal_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_epoch_seconds,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [5:0]       m_second,
    output logic [5:0]       m_minute,
    output logic [4:0]       m_hour,
    output logic [4:0]       m_month_day,
    output logic [3:0]       m_month,
    output logic [7:0]       m_years_since_1900,
    output logic [2:0]       m_weekday,
    output logic [8:0]       m_year_day
);
    logic   en;
    logic   split_valid;
    split_t split;
    cal_t   cal;

    // pipeline advances whenever the output word is free or being taken
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    epcal_daysplit u_daysplit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (s_valid),
        .in_seconds (s_epoch_seconds),
        .out_valid  (split_valid),
        .out_split  (split)
    );

    epcal_fields u_fields (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (split_valid),
        .in_split  (split),
        .out_valid (m_valid),
        .out_cal   (cal)
    );

    assign m_second           = cal.second;
    assign m_minute           = cal.minute;
    assign m_hour             = cal.hour;
    assign m_month_day        = cal.month_day;
    assign m_month            = cal.month;
    assign m_years_since_1900 = cal.years_since_1900;
    assign m_weekday          = cal.weekday;
    assign m_year_day         = cal.year_day;

    a_time_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_second < 6'd60) && (m_minute < 6'd60) && (m_hour < 5'd24))
        else $error("time of day out of range");

    a_date_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_month < 4'd12) && (m_month_day != 5'd0) && (m_year_day < 9'd366))
        else $error("date out of range");

    a_wday_year: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_weekday < 3'd7) && (m_years_since_1900 != 8'd0)
            && (m_years_since_1900 < 8'd139))
        else $error("weekday or year out of range");

endmodule
`default_nettype wire
